>>> hw/rtl/rpn_stack_calculator_unit_defines.svh
// assertion macros shared by the rpn calculator rtl
// each macro assumes clk and rst_n in the enclosing module
`ifndef RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH
`define RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// condition holds at every edge out of reset
`define RPN_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rpn assertion failed");
// consequent holds in the same cycle as the antecedent
`define RPN_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn assertion failed");
// consequent holds in the cycle after the antecedent
`define RPN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn assertion failed");
`else
`define RPN_ASSERT_ALWAYS(label, cond)
`define RPN_ASSERT_IMPL(label, ante, cons)
`define RPN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

    // signed q16.16 value
    typedef logic signed [31:0] q16_t;

    // command codes
    localparam logic [3:0] CMD_PUSH      = 4'd0;
    localparam logic [3:0] CMD_ADD       = 4'd1;
    localparam logic [3:0] CMD_SUB       = 4'd2;
    localparam logic [3:0] CMD_MUL       = 4'd3;
    localparam logic [3:0] CMD_DIV       = 4'd4;
    localparam logic [3:0] CMD_REM       = 4'd5;
    localparam logic [3:0] CMD_SHOW      = 4'd6;
    localparam logic [3:0] CMD_DUP       = 4'd7;
    localparam logic [3:0] CMD_SWAP      = 4'd8;
    localparam logic [3:0] CMD_CLEAR     = 4'd9;
    localparam logic [3:0] CMD_POP_PRINT = 4'd10;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // saturation limits
    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;

    // sequencer to arithmetic unit
    typedef struct packed {
        logic       start;
        logic [3:0] op;
    } alu_ctrl_t;

    // arithmetic unit back to sequencer
    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpn_cmd_if.sv
`default_nettype none

interface rpn_cmd_if;
    logic              valid;
    logic              ready;
    logic [3:0]        req_type;
    rpn_pkg::q16_t     operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rpn_rsp_if.sv
`default_nettype none

interface rpn_rsp_if;
    logic              valid;
    logic              ready;
    rpn_pkg::q16_t     shown_value;
    logic              shown_valid;
    logic [1:0]        status;
    logic [7:0]        stack_depth;

    modport source (output valid, output shown_value, output shown_valid,
                    output status, output stack_depth, input ready);
    modport sink   (input valid, input shown_value, input shown_valid,
                    input status, input stack_depth, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rpn_alu.sv
`default_nettype none
`include "rpn_stack_calculator_unit_defines.svh"

module rpn_alu
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rpn_pkg::alu_ctrl_t  ctrl,
    input  wire rpn_pkg::q16_t       a,
    input  wire rpn_pkg::q16_t       b,
    output rpn_pkg::alu_stat_t       stat,
    output rpn_pkg::q16_t            result
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_FIX  = 2'd3;

    // divide runs over 48 dividend bits, remainder over the upper 32 that hold the magnitude of a
    localparam logic [5:0] DIV_LAST = 6'd47;
    localparam logic [5:0] REM_LAST = 6'd31;

    localparam logic [47:0] QUO_NEG_LIM = 48'h0000_8000_0000;
    localparam logic [47:0] QUO_POS_LIM = 48'h0000_7FFF_FFFF;

    logic [1:0]           state_reg,  state_next;
    logic                 done_reg,   done_next;
    logic                 dz_reg,     dz_next;
    rpn_pkg::q16_t        result_reg, result_next;
    logic signed [63:0]   prod_reg,   prod_next;
    logic [31:0]          rem_reg,    rem_next;
    logic [47:0]          quo_reg,    quo_next;
    logic [31:0]          dvs_reg,    dvs_next;
    logic [5:0]           cnt_reg,    cnt_next;
    logic                 neg_q_reg,  neg_q_next;
    logic                 neg_r_reg,  neg_r_next;
    logic                 is_rem_reg, is_rem_next;

    logic [32:0]          add_sum;
    logic [32:0]          sub_diff;
    logic [31:0]          abs_a;
    logic [31:0]          abs_b;
    logic [47:0]          mul_sh;
    logic                 mul_fits;
    logic [32:0]          trial;
    logic [33:0]          trial_diff;
    logic                 take;

    // operand conditioning, add/sub sums and the product range check
    always_comb
    begin
        add_sum  = {a[31], a} + {b[31], b};
        sub_diff = {a[31], a} - {b[31], b};
        abs_a    = a[31] ? (~a + 32'd1) : a;
        abs_b    = b[31] ? (~b + 32'd1) : b;
        mul_sh   = prod_reg[63:16];
        mul_fits = (&mul_sh[47:31]) | (~|mul_sh[47:31]);
    end

    // one restoring divide step
    always_comb
    begin
        trial      = {rem_reg, quo_reg[47]};
        trial_diff = {1'b0, trial} - {2'b00, dvs_reg};
        take       = ~trial_diff[33];
    end

    // sequencing of the shared unit
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        dz_next     = dz_reg;
        result_next = result_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        is_rem_next = is_rem_reg;

        unique case (state_reg)
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    dz_next = 1'b0;
                    case (ctrl.op) inside
                        rpn_pkg::CMD_ADD:
                        begin
                            result_next = (add_sum[32] != add_sum[31])
                                        ? (add_sum[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX)
                                        : add_sum[31:0];
                            done_next   = 1'b1;
                        end
                        rpn_pkg::CMD_SUB:
                        begin
                            result_next = (sub_diff[32] != sub_diff[31])
                                        ? (sub_diff[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX)
                                        : sub_diff[31:0];
                            done_next   = 1'b1;
                        end
                        rpn_pkg::CMD_MUL:
                        begin
                            prod_next  = a * b;
                            state_next = A_MUL;
                        end
                        rpn_pkg::CMD_DIV, rpn_pkg::CMD_REM:
                        begin
                            if (b == 32'sd0)
                            begin
                                result_next = 32'sd0;
                                dz_next     = 1'b1;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rem_next    = 32'd0;
                                quo_next    = {abs_a, 16'd0};
                                dvs_next    = abs_b;
                                neg_q_next  = a[31] ^ b[31];
                                neg_r_next  = a[31];
                                is_rem_next = (ctrl.op == rpn_pkg::CMD_REM);
                                cnt_next    = (ctrl.op == rpn_pkg::CMD_REM) ? REM_LAST
                                                                            : DIV_LAST;
                                state_next  = A_DIV;
                            end
                        end
                        default:
                        begin
                            result_next = 32'sd0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                // floor shift by 16 then clamp
                result_next = mul_fits ? mul_sh[31:0]
                                       : (mul_sh[47] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX);
                done_next   = 1'b1;
                state_next  = A_IDLE;
            end
            A_DIV:
            begin
                rem_next = take ? trial_diff[31:0] : trial[31:0];
                quo_next = {quo_reg[46:0], take};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                // restore signs, clamp the quotient
                if (is_rem_reg)
                begin
                    result_next = neg_r_reg ? (~rem_reg + 32'd1) : rem_reg;
                end
                else if (neg_q_reg)
                begin
                    result_next = (quo_reg > QUO_NEG_LIM) ? rpn_pkg::Q_MIN
                                                          : (~quo_reg[31:0] + 32'd1);
                end
                else
                begin
                    result_next = (quo_reg > QUO_POS_LIM) ? rpn_pkg::Q_MAX
                                                          : quo_reg[31:0];
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dz_reg     <= dz_next;
        result_reg <= result_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        cnt_reg    <= cnt_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        is_rem_reg <= is_rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.div_zero = dz_reg;
    assign result        = result_reg;

    // a new operation only starts on an idle unit
    `RPN_ASSERT_IMPL(a_alu_start_idle, ctrl.start, state_reg == A_IDLE)
    // the finish flag is a single-cycle pulse
    `RPN_ASSERT_NEXT(a_alu_done_pulse, done_reg && !ctrl.start, !done_reg)

endmodule

`default_nettype wire

>>> hw/rtl/rpn_stack_calculator_unit.sv
// throughput: one command at a time, the next accepted the cycle after a result is loaded;
// the 48-step divide loop of the shared unit sets the longest gap between commands,
// and a result held by the receiver stalls the next command at its response step
// reset: asynchronous active low, empties the stack and drops any pending result
`default_nettype none
`include "rpn_stack_calculator_unit_defines.svh"

module rpn_stack_calculator_unit
#(
    parameter int STACK_DEPTH = 128
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rpn_cmd_if.sink     cmd,
    rpn_rsp_if.source   rsp
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(STACK_DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_B     = 4'd1;
    localparam logic [3:0] S_GET_B    = 4'd2;
    localparam logic [3:0] S_GET_A    = 4'd3;
    localparam logic [3:0] S_ALU_GO   = 4'd4;
    localparam logic [3:0] S_ALU_WAIT = 4'd5;
    localparam logic [3:0] S_PUSH1    = 4'd6;
    localparam logic [3:0] S_PUSH2    = 4'd7;
    localparam logic [3:0] S_RESP     = 4'd8;

    logic [3:0]           state_reg,     state_next;
    logic [PTR_W-1:0]     sp_reg,        sp_next;
    logic                 have_reg,      have_next;
    logic                 two_push_reg,  two_push_next;
    logic                 f_empty_reg,   f_empty_next;
    logic                 f_div0_reg,    f_div0_next;
    logic                 f_full_reg,    f_full_next;
    logic                 out_valid_reg, out_valid_next;

    logic [3:0]           cmd_reg,       cmd_next;
    rpn_pkg::q16_t        a_reg,         a_next;
    rpn_pkg::q16_t        b_reg,         b_next;
    rpn_pkg::q16_t        val1_reg,      val1_next;
    rpn_pkg::q16_t        val2_reg,      val2_next;
    rpn_pkg::q16_t        shown_reg,     shown_next;
    logic                 shown_vld_reg, shown_vld_next;
    rpn_pkg::q16_t        out_value_reg, out_value_next;
    logic                 out_vld_reg,   out_vld_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [7:0]           out_depth_reg, out_depth_next;

    logic [31:0]          stack_mem [STACK_DEPTH];
    logic [31:0]          mem_rdata_reg;
    logic                 mem_wr;
    logic                 mem_rd;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [31:0]          mem_wdata;

    logic [PTR_W-1:0]     sp_dec;
    logic                 sp_empty;
    logic                 sp_full;
    rpn_pkg::q16_t        rd_val;
    logic [1:0]           status_val;
    logic                 cmd_fire;

    rpn_pkg::alu_ctrl_t   alu_ctrl;
    rpn_pkg::alu_stat_t   alu_stat;
    rpn_pkg::q16_t        alu_result;

    // shared arithmetic unit
    rpn_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .a      (a_reg),
        .b      (b_reg),
        .stat   (alu_stat),
        .result (alu_result)
    );

    // pointer helpers, read data select, command handshake and status priority
    always_comb
    begin
        sp_dec     = sp_reg - PTR_W'(1);
        sp_empty   = (sp_reg == '0);
        sp_full    = (sp_reg >= PTR_MAX);
        rd_val     = have_reg ? mem_rdata_reg : 32'sd0;
        cmd_fire   = cmd.valid && cmd.ready;
        if (f_empty_reg)
            status_val = rpn_pkg::ST_EMPTY;
        else if (f_div0_reg)
            status_val = rpn_pkg::ST_DIV0;
        else if (f_full_reg)
            status_val = rpn_pkg::ST_FULL;
        else
            status_val = rpn_pkg::ST_OK;
    end

    // command sequencer
    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        have_next       = have_reg;
        two_push_next   = two_push_reg;
        f_empty_next    = f_empty_reg;
        f_div0_next     = f_div0_reg;
        f_full_next     = f_full_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        val1_next       = val1_reg;
        val2_next       = val2_reg;
        shown_next      = shown_reg;
        shown_vld_next  = shown_vld_reg;
        out_value_next  = out_value_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_depth_next  = out_depth_reg;
        mem_wr          = 1'b0;
        mem_rd          = 1'b0;
        mem_waddr       = sp_reg[ADDR_W-1:0];
        mem_raddr       = sp_dec[ADDR_W-1:0];
        mem_wdata       = val1_reg;
        alu_ctrl.start  = 1'b0;
        alu_ctrl.op     = cmd_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    cmd_next       = cmd.req_type;
                    f_empty_next   = 1'b0;
                    f_div0_next    = 1'b0;
                    f_full_next    = 1'b0;
                    shown_next     = 32'sd0;
                    shown_vld_next = 1'b0;
                    two_push_next  = 1'b0;
                    unique case (cmd.req_type) inside
                        rpn_pkg::CMD_PUSH:
                        begin
                            val1_next  = cmd.operand_value;
                            state_next = S_PUSH1;
                        end
                        rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
                        rpn_pkg::CMD_DIV, rpn_pkg::CMD_REM, rpn_pkg::CMD_SHOW,
                        rpn_pkg::CMD_DUP, rpn_pkg::CMD_SWAP, rpn_pkg::CMD_POP_PRINT:
                        begin
                            state_next = S_RD_B;
                        end
                        rpn_pkg::CMD_CLEAR:
                        begin
                            sp_next    = '0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RD_B:
            begin
                // top entry; show top peeks without popping
                if (!sp_empty)
                begin
                    mem_rd    = 1'b1;
                    have_next = 1'b1;
                    if (cmd_reg != rpn_pkg::CMD_SHOW)
                        sp_next = sp_dec;
                end
                else
                begin
                    have_next    = 1'b0;
                    f_empty_next = 1'b1;
                end
                state_next = S_GET_B;
            end
            S_GET_B:
            begin
                b_next = rd_val;
                unique case (cmd_reg) inside
                    rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
                    rpn_pkg::CMD_DIV, rpn_pkg::CMD_REM, rpn_pkg::CMD_SWAP:
                    begin
                        // second operand pop
                        if (!sp_empty)
                        begin
                            mem_rd    = 1'b1;
                            have_next = 1'b1;
                            sp_next   = sp_dec;
                        end
                        else
                        begin
                            have_next    = 1'b0;
                            f_empty_next = 1'b1;
                        end
                        state_next = S_GET_A;
                    end
                    rpn_pkg::CMD_SHOW:
                    begin
                        shown_next     = rd_val;
                        shown_vld_next = have_reg;
                        state_next     = S_RESP;
                    end
                    rpn_pkg::CMD_POP_PRINT:
                    begin
                        shown_next     = rd_val;
                        shown_vld_next = 1'b1;
                        state_next     = S_RESP;
                    end
                    rpn_pkg::CMD_DUP:
                    begin
                        val1_next     = rd_val;
                        val2_next     = rd_val;
                        two_push_next = 1'b1;
                        state_next    = S_PUSH1;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_GET_A:
            begin
                a_next = rd_val;
                if (cmd_reg == rpn_pkg::CMD_SWAP)
                begin
                    val1_next     = b_reg;
                    val2_next     = rd_val;
                    two_push_next = 1'b1;
                    state_next    = S_PUSH1;
                end
                else
                begin
                    state_next = S_ALU_GO;
                end
            end
            S_ALU_GO:
            begin
                alu_ctrl.start = 1'b1;
                state_next     = S_ALU_WAIT;
            end
            S_ALU_WAIT:
            begin
                if (alu_stat.done)
                begin
                    val1_next   = alu_result;
                    f_div0_next = alu_stat.div_zero;
                    state_next  = S_PUSH1;
                end
            end
            S_PUSH1:
            begin
                if (!sp_full)
                begin
                    mem_wr  = 1'b1;
                    sp_next = sp_reg + PTR_W'(1);
                end
                else
                begin
                    f_full_next = 1'b1;
                end
                state_next = two_push_reg ? S_PUSH2 : S_RESP;
            end
            S_PUSH2:
            begin
                mem_wdata = val2_reg;
                if (!sp_full)
                begin
                    mem_wr  = 1'b1;
                    sp_next = sp_reg + PTR_W'(1);
                end
                else
                begin
                    f_full_next = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // load the result register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = shown_reg;
                    out_vld_next    = shown_vld_reg;
                    out_status_next = status_val;
                    out_depth_next  = 8'(sp_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            stack_mem[mem_waddr] <= mem_wdata;
        if (mem_rd)
            mem_rdata_reg <= stack_mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            have_reg      <= 1'b0;
            two_push_reg  <= 1'b0;
            f_empty_reg   <= 1'b0;
            f_div0_reg    <= 1'b0;
            f_full_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            have_reg      <= have_next;
            two_push_reg  <= two_push_next;
            f_empty_reg   <= f_empty_next;
            f_div0_reg    <= f_div0_next;
            f_full_reg    <= f_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        val1_reg       <= val1_next;
        val2_reg       <= val2_next;
        shown_reg      <= shown_next;
        shown_vld_reg  <= shown_vld_next;
        out_value_reg  <= out_value_next;
        out_vld_reg    <= out_vld_next;
        out_status_reg <= out_status_next;
        out_depth_reg  <= out_depth_next;
    end

    // ports
    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.shown_value = out_value_reg;
    assign rsp.shown_valid = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.stack_depth = out_depth_reg;

    // entry count never passes the stack size
    `RPN_ASSERT_ALWAYS(a_sp_bound, sp_reg <= PTR_MAX)
    // writes only land inside the stack
    `RPN_ASSERT_IMPL(a_wr_in_range, mem_wr, sp_reg < PTR_MAX)
    // arithmetic results only arrive while the sequencer waits for them
    `RPN_ASSERT_IMPL(a_alu_done_wait, alu_stat.done, state_reg == S_ALU_WAIT)
    // an accepted transaction always leaves idle
    `RPN_ASSERT_NEXT(a_cmd_leaves_idle, cmd_fire, state_reg != S_IDLE)

endmodule

`default_nettype wire

>>> bench/rpn_stack_calculator_unit_tb.sv
module rpn_stack_calculator_unit_tb;
    import rpn_pkg::*;

    localparam int         DEPTH            = 128;
    localparam int         ITEM_GOAL        = 1550;
    localparam int         HOLD_CYCLES      = 400;
    localparam int         DRAIN_CYCLES     = 80;
    localparam int         MAX_REPORTS      = 40;
    localparam logic [3:0] CMD_FIRST_UNUSED = CMD_POP_PRINT + 4'd1;

    // values used by the directed and random commands
    localparam q16_t Q_ZERO      = 32'sh0000_0000;
    localparam q16_t Q_ONE       = 32'sh0001_0000;
    localparam q16_t Q_MINUS_ONE = 32'shFFFF_0000;
    localparam q16_t Q_TWO       = 32'sh0002_0000;
    localparam q16_t Q_THREE     = 32'sh0003_0000;
    localparam q16_t Q_M7_5      = 32'shFFF8_8000;
    localparam q16_t Q_HALF      = 32'sh0000_8000;
    localparam q16_t Q_LSB       = 32'sh0000_0001;

    typedef struct packed {
        logic [3:0] req_type;
        q16_t       operand_value;
    } command_t;

    typedef struct packed {
        q16_t       shown_value;
        logic       shown_valid;
        logic [1:0] status;
        logic [7:0] stack_depth;
    } answer_t;

    logic clk;
    logic rst_n;

    rpn_cmd_if cmd_bus ();
    rpn_rsp_if rsp_bus ();

    rpn_stack_calculator_unit #(
        .STACK_DEPTH(DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    command_t    cmd_queue[$];
    answer_t     awaited_answers[$];

    // calculator state as the bench sees it
    q16_t        calc_stack [DEPTH];
    int unsigned calc_depth = 0;

    // depth the command planner expects, used only to shape sequences
    int          plan_depth = 0;
    int          planned_items = 0;
    int          total_cmds = 0;

    int          cmds_accepted = 0;
    int          answers_checked = 0;
    int          error_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    int          empty_seen = 0;
    int          div0_seen = 0;
    int          full_seen = 0;
    int          shown_seen = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #6000000;
        $display("rpn_stack_calculator_unit_tb: FAIL");
        $finish;
    end

    task automatic flag_mismatch(string what);
        error_count++;
        // further mismatches are counted only
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic longint clamp_q16(longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    // pop one entry, zero with a flag on an empty stack
    function automatic longint pull_entry(inout bit empty_hit);
        if (calc_depth == 0)
        begin
            empty_hit = 1'b1;
            return 0;
        end
        calc_depth--;
        return longint'(calc_stack[calc_depth]);
    endfunction

    // push one entry, dropped with a flag on a full stack
    function automatic void place_entry(longint v, inout bit full_hit);
        if (calc_depth < DEPTH)
        begin
            calc_stack[calc_depth] = q16_t'(v);
            calc_depth++;
        end
        else
        begin
            full_hit = 1'b1;
        end
    endfunction

    // apply one command to the calculator state and queue its answer
    function automatic void predict_answer(logic [3:0] code, q16_t value);
        longint  a;
        longint  b;
        longint  r;
        bit      empty_hit;
        bit      div0_hit;
        bit      full_hit;
        answer_t ans;
        empty_hit = 1'b0;
        div0_hit  = 1'b0;
        full_hit  = 1'b0;
        ans       = '0;
        case (code)
            CMD_PUSH:
                place_entry(longint'(value), full_hit);
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM:
            begin
                b = pull_entry(empty_hit);
                a = pull_entry(empty_hit);
                r = 0;
                if (code == CMD_ADD)
                    r = clamp_q16(a + b);
                else if (code == CMD_SUB)
                    r = clamp_q16(a - b);
                else if (code == CMD_MUL)
                    // arithmetic shift rounds toward minus infinity
                    r = clamp_q16((a * b) >>> 16);
                else if (b == 0)
                    div0_hit = 1'b1;
                else if (code == CMD_DIV)
                    r = clamp_q16((a * 65536) / b);
                else
                    r = a % b;
                place_entry(r, full_hit);
            end
            CMD_SHOW:
            begin
                if (calc_depth == 0)
                begin
                    empty_hit = 1'b1;
                end
                else
                begin
                    ans.shown_value = calc_stack[calc_depth - 1];
                    ans.shown_valid = 1'b1;
                end
            end
            CMD_DUP:
            begin
                a = pull_entry(empty_hit);
                place_entry(a, full_hit);
                place_entry(a, full_hit);
            end
            CMD_SWAP:
            begin
                b = pull_entry(empty_hit);
                a = pull_entry(empty_hit);
                place_entry(b, full_hit);
                place_entry(a, full_hit);
            end
            CMD_CLEAR:
                calc_depth = 0;
            CMD_POP_PRINT:
            begin
                ans.shown_value = q16_t'(pull_entry(empty_hit));
                ans.shown_valid = 1'b1;
            end
            default:
                ;
        endcase

        // lowest nonzero code wins
        if (empty_hit)
            ans.status = ST_EMPTY;
        else if (div0_hit)
            ans.status = ST_DIV0;
        else if (full_hit)
            ans.status = ST_FULL;
        else
            ans.status = ST_OK;
        ans.stack_depth = 8'(calc_depth);

        if (empty_hit)
            empty_seen++;
        if (div0_hit)
            div0_seen++;
        if (full_hit)
            full_seen++;
        if (ans.shown_valid)
            shown_seen++;
        awaited_answers.push_back(ans);
    endfunction

    // stack depth after a command, for the planner only
    function automatic int depth_after(logic [3:0] code, int d);
        case (code)
            CMD_PUSH:
                return (d < DEPTH) ? d + 1 : d;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM:
                return (d >= 2) ? d - 1 : 1;
            CMD_DUP:
                return (d == 0) ? 2 : ((d < DEPTH) ? d + 1 : d);
            CMD_SWAP:
                return (d < 2) ? 2 : d;
            CMD_CLEAR:
                return 0;
            CMD_POP_PRINT:
                return (d > 0) ? d - 1 : 0;
            default:
                return d;
        endcase
    endfunction

    function automatic q16_t pick_operand();
        int unsigned sel;
        int          k;
        sel = $urandom_range(99);
        if (sel < 30)
            return q16_t'($urandom);
        if (sel < 50)
        begin
            k = int'($urandom_range(200)) - 100;
            return q16_t'(k * 65536);
        end
        if (sel < 65)
        begin
            k = int'($urandom_range(2000000)) - 1000000;
            return q16_t'(k);
        end
        if (sel < 75)
            return Q_ZERO;
        case ($urandom_range(7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return Q_LSB;
            3: return -Q_LSB;
            4: return Q_ONE;
            5: return Q_MINUS_ONE;
            6: return Q_HALF;
            default: return Q_TWO;
        endcase
    endfunction

    // any arithmetic or stack operation but push, clear kept rare
    function automatic logic [3:0] pick_op();
        logic [3:0] op;
        op = CMD_ADD + 4'($urandom_range(8));
        if (op == CMD_CLEAR && $urandom_range(3) != 0)
            op = CMD_POP_PRINT;
        return op;
    endfunction

    function automatic void plan_cmd(logic [3:0] code, q16_t value);
        command_t c;
        c.req_type      = code;
        c.operand_value = value;
        cmd_queue.push_back(c);
        plan_depth = depth_after(code, plan_depth);
        if (code <= CMD_POP_PRINT)
            planned_items++;
    endfunction

    // fill to the top, then push, duplicate and show on the full stack, then one random operation
    function automatic void fill_stack();
        while (plan_depth < DEPTH)
            plan_cmd(($urandom_range(3) == 0) ? CMD_DUP : CMD_PUSH, pick_operand());
        plan_cmd(CMD_PUSH, pick_operand());
        plan_cmd(CMD_DUP, pick_operand());
        plan_cmd(CMD_SHOW, pick_operand());
        plan_cmd(pick_op(), pick_operand());
    endfunction

    // idle share per phase: sender first light, then heavy, then none
    function automatic int idle_share(bit for_sender);
        if (cmds_accepted < total_cmds / 3)
            return for_sender ? 24 : 65;
        if (cmds_accepted < (2 * total_cmds) / 3)
            return for_sender ? 65 : 24;
        return 0;
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        command_t c;
        int       idle_pct;
        if (!rst_n)
        begin
            cmd_bus.valid         <= 1'b0;
            cmd_bus.req_type      <= CMD_PUSH;
            cmd_bus.operand_value <= Q_ZERO;
        end
        else
        begin
            idle_pct = idle_share(1'b1);
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                predict_answer(cmd_bus.req_type, cmd_bus.operand_value);
                cmds_accepted <= cmds_accepted + 1;
            end
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    c = cmd_queue.pop_front();
                    cmd_bus.valid         <= 1'b1;
                    cmd_bus.req_type      <= c.req_type;
                    cmd_bus.operand_value <= c.operand_value;
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off late in the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && cmds_accepted >= (total_cmds * 5) / 6)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // answer monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : collect_proc
        answer_t want;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    flag_mismatch("answer transaction with no command outstanding");
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    answers_checked++;
                    if (rsp_bus.shown_value !== want.shown_value)
                        flag_mismatch($sformatf("answer %0d shown_value %h, wanted %h",
                            answers_checked, rsp_bus.shown_value, want.shown_value));
                    if (rsp_bus.shown_valid !== want.shown_valid)
                        flag_mismatch($sformatf("answer %0d shown_valid %b, wanted %b",
                            answers_checked, rsp_bus.shown_valid, want.shown_valid));
                    if (rsp_bus.status !== want.status)
                        flag_mismatch($sformatf("answer %0d status %0d, wanted %0d",
                            answers_checked, rsp_bus.status, want.status));
                    if (rsp_bus.stack_depth !== want.stack_depth)
                        flag_mismatch($sformatf("answer %0d stack_depth %0d, wanted %0d",
                            answers_checked, rsp_bus.stack_depth, want.stack_depth));
                end
            end
            rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_share(1'b0));
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin : stimulus_proc
        int unsigned sel;
        int          n;
        logic [3:0]  op;

        rst_n                 = 1'b0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.req_type      = CMD_PUSH;
        cmd_bus.operand_value = Q_ZERO;
        rsp_bus.ready         = 1'b0;

        // empty stack behaviour: missing operands, show and print on empty
        plan_cmd(CMD_ADD, Q_ZERO);
        plan_cmd(CMD_SWAP, Q_ZERO);
        plan_cmd(CMD_CLEAR, Q_ZERO);
        plan_cmd(CMD_SHOW, Q_ZERO);
        plan_cmd(CMD_POP_PRINT, Q_ZERO);
        plan_cmd(CMD_DUP, Q_ZERO);
        // saturation of add and sub
        plan_cmd(CMD_PUSH, Q_MAX);
        plan_cmd(CMD_PUSH, Q_MAX);
        plan_cmd(CMD_ADD, Q_ZERO);
        plan_cmd(CMD_PUSH, Q_MIN);
        plan_cmd(CMD_SUB, Q_ZERO);
        // divide and remainder by zero
        plan_cmd(CMD_PUSH, Q_THREE);
        plan_cmd(CMD_PUSH, Q_ZERO);
        plan_cmd(CMD_DIV, Q_ZERO);
        plan_cmd(CMD_PUSH, Q_ZERO);
        plan_cmd(CMD_REM, Q_ZERO);
        // remainder keeps the sign of the dividend
        plan_cmd(CMD_PUSH, Q_M7_5);
        plan_cmd(CMD_PUSH, Q_TWO);
        plan_cmd(CMD_REM, Q_ZERO);
        // most negative over minus one saturates, then a saturating product
        plan_cmd(CMD_PUSH, Q_MIN);
        plan_cmd(CMD_PUSH, Q_MINUS_ONE);
        plan_cmd(CMD_DIV, Q_ZERO);
        plan_cmd(CMD_PUSH, Q_MIN);
        plan_cmd(CMD_MUL, Q_ZERO);
        plan_cmd(CMD_FIRST_UNUSED, Q_MAX);
        plan_cmd(CMD_POP_PRINT, Q_ZERO);

        // full stack early on
        fill_stack();

        // random sequences
        while (planned_items < ITEM_GOAL)
        begin
            sel = $urandom_range(99);
            if (sel < 62)
            begin
                // operands mixed with operations
                n = $urandom_range(6, 1);
                repeat (n)
                begin
                    if (plan_depth < 2 || $urandom_range(99) < 35)
                        plan_cmd(CMD_PUSH, pick_operand());
                    else
                        plan_cmd(pick_op(), pick_operand());
                end
            end
            else if (sel < 76)
            begin
                // noise: any code, unused ones included
                plan_cmd(4'($urandom_range(15)), q16_t'($urandom));
            end
            else if (sel < 88)
            begin
                // drain, then operate on the empty stack
                while (plan_depth > 0)
                    plan_cmd(CMD_POP_PRINT, pick_operand());
                n = $urandom_range(3, 1);
                repeat (n)
                    plan_cmd(CMD_ADD + 4'($urandom_range(9)), pick_operand());
            end
            else if (sel < 98)
            begin
                // dup, swap and show on a short stack
                plan_cmd(CMD_CLEAR, pick_operand());
                if ($urandom_range(1) != 0)
                    plan_cmd(CMD_PUSH, pick_operand());
                n = $urandom_range(3, 1);
                repeat (n)
                begin
                    case ($urandom_range(2))
                        0: op = CMD_DUP;
                        1: op = CMD_SWAP;
                        default: op = CMD_SHOW;
                    endcase
                    plan_cmd(op, pick_operand());
                end
            end
            else
            begin
                fill_stack();
            end
        end
        total_cmds = cmd_queue.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // all commands taken, all answers in, then a quiet tail
        while (cmds_accepted < total_cmds)
            @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d commands, %0d answers checked, %0d mismatches",
            cmds_accepted, answers_checked, error_count);
        $display("missing operand %0d, divide by zero %0d, full stack %0d, values shown %0d",
            empty_seen, div0_seen, full_seen, shown_seen);
        if (error_count == 0)
            $display("rpn_stack_calculator_unit_tb: PASS");
        else
            $display("rpn_stack_calculator_unit_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_cmd_if.sv
hw/rtl/rpn_rsp_if.sv
hw/rtl/rpn_alu.sv
hw/rtl/rpn_stack_calculator_unit.sv
bench/rpn_stack_calculator_unit_tb.sv
